// ===== design/dmxr_pkg.sv =====
// Shared constants and types of the DMX512 frame receiver.
package dmxr_pkg;

  // Slot buffer geometry
  localparam int unsigned MaxSlots = 513;
  localparam int unsigned CntW     = $clog2(MaxSlots + 1);
  localparam int unsigned AddrW    = $clog2(MaxSlots);

  // Field widths
  localparam int unsigned ActionW  = 3;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChanW    = 10;
  localparam int unsigned PktSizeW = 10;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StateW   = 2;
  localparam int unsigned CfgIdxW  = 2;

  // DMX512 timing: break + mark-after-break + first slot, and one slot
  localparam int unsigned FirstSlotMinUs = 88 + 8 + 44;
  localparam int unsigned SlotTimeUs     = 44;

  // Configuration reset values
  localparam logic [TimeW-1:0] MinPacketRst = 32'd1204;
  localparam logic [TimeW-1:0] MaxPacketRst = 32'd1000000;
  localparam logic [TimeW-1:0] MaxIdleRst   = 32'd1000000;

  typedef enum logic [ActionW-1:0] {
    ACT_BYTE      = 3'd0,
    ACT_BREAK     = 3'd1,
    ACT_BAD_BREAK = 3'd2,
    ACT_TICK      = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic [StateW-1:0] {
    RX_IDLE  = 2'd0,
    RX_BREAK = 2'd1,
    RX_DATA  = 2'd2
  } rx_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_PACKET = 2'd0,
    CFG_MAX_PACKET = 2'd1,
    CFG_MAX_IDLE   = 2'd2
  } cfg_reg_e;

  // Double-buffer bookkeeping touched when a packet completes
  typedef struct packed {
    logic              active_is_b;
    logic [CntW-1:0]   fill;
    logic [CntW-1:0]   ready;
    logic [CountW-1:0] packets;
  } pkt_ctx_t;

endpackage

// ===== design/dmx512_frame_receiver.sv =====
// Top level of the DMX512 frame receiver: event decode, timing checks and double buffer.
//
// Usage: each input transaction carries one timestamped event (slot byte, potential
// BREAK, bad BREAK, timeout tick or slot read) on action_i/time_us_i/data_byte_i,
// with read_channel_i/release_packet_i for reads. Every event yields exactly one
// result transaction: the read outcome plus packet size, receiver state, connection
// flag and the four wrapping event counters as they stand after the event.
// Configuration registers (0 min packet time, 1 max packet time, 2 max idle time)
// are written over the cfg channel, which is always ready; write only while idle.
// Throughput: one event per cycle while in_stall_o is low. The event is resolved against
// the scalar state in its accept cycle; the slot buffers are two RAMs with registered
// reads, one written with the incoming slot while the other serves reads of the completed
// packet. Result path: the accept edge loads the read stage, which hands the result to the
// output register once that register is free; the output register presents the result.
// Stall: while out_stall_i is high the output register holds; one more event is
// taken into the read stage, after which in_stall_o rises until output drains.
// Reset: idle state, counters and sizes cleared, configuration to its defaults.
// Buffer contents are not cleared; only written slots of a completed packet read.
module dmx512_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Event channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dmxr_pkg::ActionW-1:0]   action_i,
  input  logic [dmxr_pkg::TimeW-1:0]     time_us_i,
  input  logic [dmxr_pkg::ByteW-1:0]     data_byte_i,
  input  logic [dmxr_pkg::ChanW-1:0]     read_channel_i,
  input  logic                           release_packet_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           read_valid_o,
  output logic [dmxr_pkg::ByteW-1:0]     read_data_o,
  output logic [dmxr_pkg::PktSizeW-1:0]  packet_size_o,
  output logic [dmxr_pkg::StateW-1:0]    receiver_state_o,
  output logic                           connected_o,
  output logic [dmxr_pkg::CountW-1:0]    packet_count_o,
  output logic [dmxr_pkg::CountW-1:0]    timeout_count_o,
  output logic [dmxr_pkg::CountW-1:0]    framing_error_count_o,
  output logic [dmxr_pkg::CountW-1:0]    short_packet_count_o,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dmxr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dmxr_pkg::TimeW-1:0]     cfg_data_i
);

  import dmxr_pkg::*;

  // Result fields that travel through the read stage and output register
  typedef struct packed {
    logic                read_valid;
    logic                read_bank_a;
    logic [PktSizeW-1:0] packet_size;
    logic [StateW-1:0]   rx_state;
    logic                connected;
    logic [CountW-1:0]   packets;
    logic [CountW-1:0]   timeouts;
    logic [CountW-1:0]   bad_breaks;
    logic [CountW-1:0]   short_packets;
  } result_t;

  // Publish the filled buffer if it holds any slots
  function automatic pkt_ctx_t finish_packet(pkt_ctx_t c);
    pkt_ctx_t r;
    r = c;
    if (c.fill != '0) begin
      r.active_is_b = ~c.active_is_b;
      r.packets     = c.packets + CountW'(1);
      r.ready       = c.fill;
      r.fill        = '0;
    end
    return r;
  endfunction

  // Configuration
  logic [TimeW-1:0] min_packet_q, max_packet_q, max_idle_q;

  // Receiver state
  rx_state_e         rx_state_q, rx_state_d;
  pkt_ctx_t          ctx_q, ctx_d;
  logic [TimeW-1:0]  break_start_q, break_start_d;
  logic [TimeW-1:0]  last_break_q, last_break_d;
  logic [TimeW-1:0]  last_slot_end_q, last_slot_end_d;
  logic              connected_q, connected_d;
  logic [CountW-1:0] timeouts_q, timeouts_d;
  logic [CountW-1:0] bad_breaks_q, bad_breaks_d;
  logic [CountW-1:0] short_q, short_d;

  // Pipeline
  logic    in_accept, s1_adv, out_free;
  logic    s1_valid_q, out_valid_q;
  result_t s1_q, s1_d, out_q;
  logic [ByteW-1:0] out_data_q;

  // Buffer access
  logic             wr_en, wr_bank_b, rd_hit, take_slot;
  logic [AddrW-1:0] wr_addr;
  logic [ByteW-1:0] rdata_a, rdata_b, rdata_sel;

  // Timestamp differences, modulo 2^32
  logic [TimeW-1:0] since, idle_gap, bb_gap, slot_min;

  assign since    = time_us_i - break_start_q;
  assign idle_gap = time_us_i - last_slot_end_q;
  assign bb_gap   = break_start_q - last_break_q;
  assign slot_min = TimeW'(FirstSlotMinUs) + TimeW'(SlotTimeUs) * TimeW'(ctx_q.fill);

  // Handshakes
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_adv     = s1_valid_q & out_free;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_packet_q <= MinPacketRst;
      max_packet_q <= MaxPacketRst;
      max_idle_q   <= MaxIdleRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_PACKET: min_packet_q <= cfg_data_i;
        CFG_MAX_PACKET: max_packet_q <= cfg_data_i;
        CFG_MAX_IDLE:   max_idle_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Resolve one event against the current state
  always_comb begin
    rx_state_d      = rx_state_q;
    ctx_d           = ctx_q;
    break_start_d   = break_start_q;
    last_break_d    = last_break_q;
    last_slot_end_d = last_slot_end_q;
    connected_d     = connected_q;
    timeouts_d      = timeouts_q;
    bad_breaks_d    = bad_breaks_q;
    short_d         = short_q;
    take_slot       = 1'b0;
    rd_hit          = 1'b0;
    wr_en           = 1'b0;
    wr_bank_b       = 1'b0;
    wr_addr         = '0;

    if (in_accept) begin
      unique case (action_e'(action_i))
        ACT_BYTE: begin
          unique case (rx_state_q)
            RX_BREAK: begin
              if (since < TimeW'(FirstSlotMinUs)) begin
                // First slot too early: bad break
                bad_breaks_d = bad_breaks_q + CountW'(1);
                connected_d  = 1'b0;
                ctx_d.fill   = '0;
                rx_state_d   = RX_IDLE;
              end else begin
                if (connected_q) begin
                  if (bb_gap < min_packet_q) begin
                    short_d    = short_q + CountW'(1);
                    ctx_d.fill = '0;
                  end else if (bb_gap > max_packet_q) begin
                    timeouts_d = timeouts_d + CountW'(1);
                  end
                  ctx_d = finish_packet(ctx_d);
                end
                last_break_d = break_start_q;
                connected_d  = 1'b1;
                rx_state_d   = RX_DATA;
                take_slot    = 1'b1;
              end
            end
            RX_DATA: begin
              if (since < slot_min) begin
                // Slot arrived faster than the line allows
                bad_breaks_d = bad_breaks_q + CountW'(1);
                connected_d  = 1'b0;
                ctx_d.fill   = '0;
                rx_state_d   = RX_IDLE;
              end else begin
                take_slot = 1'b1;
              end
            end
            default: ;
          endcase

          // Store the slot into the active buffer
          if (take_slot) begin
            last_slot_end_d = time_us_i;
            if (since > max_packet_q) begin
              timeouts_d = timeouts_d + CountW'(1);
              ctx_d      = finish_packet(ctx_d);
              rx_state_d = RX_IDLE;
            end else begin
              if (TimeW'(ctx_d.fill) < TimeW'(MaxSlots)) begin
                wr_en      = 1'b1;
                wr_bank_b  = ctx_d.active_is_b;
                wr_addr    = ctx_d.fill[AddrW-1:0];
                ctx_d.fill = ctx_d.fill + CntW'(1);
              end
              if (TimeW'(ctx_d.fill) >= TimeW'(MaxSlots)) begin
                ctx_d      = finish_packet(ctx_d);
                rx_state_d = RX_IDLE;
              end
            end
          end
        end
        ACT_BREAK: begin
          break_start_d = time_us_i - TimeW'(SlotTimeUs);
          rx_state_d    = RX_BREAK;
        end
        ACT_BAD_BREAK: begin
          bad_breaks_d = bad_breaks_q + CountW'(1);
          connected_d  = 1'b0;
          ctx_d.fill   = '0;
          rx_state_d   = RX_IDLE;
        end
        ACT_TICK: begin
          if (rx_state_q == RX_DATA &&
              (since > max_packet_q || idle_gap >= max_idle_q)) begin
            timeouts_d  = timeouts_q + CountW'(1);
            connected_d = 1'b0;
            ctx_d       = finish_packet(ctx_q);
            rx_state_d  = RX_IDLE;
          end
        end
        ACT_READ: begin
          if (ctx_q.ready != '0) begin
            if (TimeW'(read_channel_i) < TimeW'(ctx_q.ready) &&
                TimeW'(read_channel_i) < TimeW'(MaxSlots)) begin
              rd_hit = 1'b1;
            end
            if (release_packet_i) begin
              ctx_d.ready = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_state_q      <= RX_IDLE;
      ctx_q           <= '0;
      break_start_q   <= '0;
      last_break_q    <= '0;
      last_slot_end_q <= '0;
      connected_q     <= 1'b0;
      timeouts_q      <= '0;
      bad_breaks_q    <= '0;
      short_q         <= '0;
    end else begin
      rx_state_q      <= rx_state_d;
      ctx_q           <= ctx_d;
      break_start_q   <= break_start_d;
      last_break_q    <= last_break_d;
      last_slot_end_q <= last_slot_end_d;
      connected_q     <= connected_d;
      timeouts_q      <= timeouts_d;
      bad_breaks_q    <= bad_breaks_d;
      short_q         <= short_d;
    end
  end

  // Slot buffers: write the active one, read the completed one
  dmxr_ram #(
    .Width (ByteW),
    .Depth (MaxSlots)
  ) u_buf_a (
    .clk_i   (clk_i),
    .we_i    (wr_en & ~wr_bank_b),
    .waddr_i (wr_addr),
    .wdata_i (data_byte_i),
    .re_i    (rd_hit & ctx_q.active_is_b),
    .raddr_i (read_channel_i[AddrW-1:0]),
    .rdata_o (rdata_a)
  );

  dmxr_ram #(
    .Width (ByteW),
    .Depth (MaxSlots)
  ) u_buf_b (
    .clk_i   (clk_i),
    .we_i    (wr_en & wr_bank_b),
    .waddr_i (wr_addr),
    .wdata_i (data_byte_i),
    .re_i    (rd_hit & ~ctx_q.active_is_b),
    .raddr_i (read_channel_i[AddrW-1:0]),
    .rdata_o (rdata_b)
  );

  // Capture the post-event snapshot for the read stage
  always_comb begin
    s1_d.read_valid    = rd_hit;
    s1_d.read_bank_a   = ctx_q.active_is_b;
    s1_d.packet_size   = PktSizeW'(ctx_d.ready);
    s1_d.rx_state      = rx_state_d;
    s1_d.connected     = connected_d;
    s1_d.packets       = ctx_d.packets;
    s1_d.timeouts      = timeouts_d;
    s1_d.bad_breaks    = bad_breaks_d;
    s1_d.short_packets = short_d;
  end

  // Read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Pick the buffer that holds the completed packet
  assign rdata_sel = s1_q.read_bank_a ? rdata_a : rdata_b;

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q      <= s1_q;
      out_data_q <= s1_q.read_valid ? rdata_sel : '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign read_valid_o          = out_q.read_valid;
  assign read_data_o           = out_data_q;
  assign packet_size_o         = out_q.packet_size;
  assign receiver_state_o      = out_q.rx_state;
  assign connected_o           = out_q.connected;
  assign packet_count_o        = out_q.packets;
  assign timeout_count_o       = out_q.timeouts;
  assign framing_error_count_o = out_q.bad_breaks;
  assign short_packet_count_o  = out_q.short_packets;

endmodule

// ===== design/dmxr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module dmxr_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 512,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/dmx512_frame_receiver_tb.sv =====
// Self-checking testbench for the DMX512 frame receiver: driver, monitor, status predictor.
`timescale 1ns / 1ps

module testbench;
  import dmxr_pkg::*;

  localparam int IdlePct    = 37;
  localparam int HoldCycles = 250;
  localparam int HoldAt     = 400;
  localparam int CalmFrom   = 150;
  localparam int CalmTo     = 450;
  localparam int DrainPause = 8;
  localparam int MaxReports = 10;
  localparam logic [ActionW-1:0] ActLast = ActionW'((1 << ActionW) - 1);
  // earliest legal first slot, measured from the potential break event
  localparam int unsigned FirstSlotLead = FirstSlotMinUs - SlotTimeUs;

  typedef struct packed {
    logic [ActionW-1:0] act;
    logic [TimeW-1:0]   t;
    logic [ByteW-1:0]   data;
    logic [ChanW-1:0]   chan;
    logic               rel;
  } dmx_event_t;

  typedef struct packed {
    logic                rd_valid;
    logic [ByteW-1:0]    rd_data;
    logic [PktSizeW-1:0] size;
    logic [StateW-1:0]   state;
    logic                conn;
    logic [CountW-1:0]   pkts;
    logic [CountW-1:0]   tmo;
    logic [CountW-1:0]   ferr;
    logic [CountW-1:0]   shrt;
  } dmx_status_t;

  // DUT ports
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [ActionW-1:0]  action_i         = '0;
  logic [TimeW-1:0]    time_us_i        = '0;
  logic [ByteW-1:0]    data_byte_i      = '0;
  logic [ChanW-1:0]    read_channel_i   = '0;
  logic                release_packet_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                read_valid_o;
  logic [ByteW-1:0]    read_data_o;
  logic [PktSizeW-1:0] packet_size_o;
  logic [StateW-1:0]   receiver_state_o;
  logic                connected_o;
  logic [CountW-1:0]   packet_count_o;
  logic [CountW-1:0]   timeout_count_o;
  logic [CountW-1:0]   framing_error_count_o;
  logic [CountW-1:0]   short_packet_count_o;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [TimeW-1:0]    cfg_data_i       = '0;

  dmx512_frame_receiver DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .action_i              (action_i),
    .time_us_i             (time_us_i),
    .data_byte_i           (data_byte_i),
    .read_channel_i        (read_channel_i),
    .release_packet_i      (release_packet_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .read_valid_o          (read_valid_o),
    .read_data_o           (read_data_o),
    .packet_size_o         (packet_size_o),
    .receiver_state_o      (receiver_state_o),
    .connected_o           (connected_o),
    .packet_count_o        (packet_count_o),
    .timeout_count_o       (timeout_count_o),
    .framing_error_count_o (framing_error_count_o),
    .short_packet_count_o  (short_packet_count_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i)
  );

  // Transaction queues and progress counters
  dmx_event_t  pending_events[$];
  dmx_status_t expected_status[$];
  bit          event_taken  = 1'b0;
  int          events_taken = 0;
  int          n_err        = 0;
  int          gen_count    = 0;
  logic        calm;

  assign calm = (events_taken >= CalmFrom) && (events_taken < CalmTo);

  // Receiver model state
  logic [ByteW-1:0] slot_a [MaxSlots];
  logic [ByteW-1:0] slot_b [MaxSlots];
  rx_state_e        rx_mode     = RX_IDLE;
  bit               back_is_b   = 1'b0;
  int unsigned      fill_cnt    = 0;
  int unsigned      ready_cnt   = 0;
  logic [TimeW-1:0] brk_t       = '0;
  logic [TimeW-1:0] prev_brk_t  = '0;
  logic [TimeW-1:0] last_slot_t = '0;
  bit               link_up     = 1'b0;
  logic [CountW-1:0] pkt_total   = '0;
  logic [CountW-1:0] tmo_total   = '0;
  logic [CountW-1:0] ferr_total  = '0;
  logic [CountW-1:0] short_total = '0;
  logic [TimeW-1:0] lim_min_pkt = MinPacketRst;
  logic [TimeW-1:0] lim_max_pkt = MaxPacketRst;
  logic [TimeW-1:0] lim_idle    = MaxIdleRst;

  // Stimulus generator view of time and limits
  logic [TimeW-1:0] gen_now     = '0;
  logic [TimeW-1:0] gen_max_pkt = MaxPacketRst;
  logic [TimeW-1:0] gen_idle    = MaxIdleRst;
  int unsigned      gen_len     = 0;

  // Swap a non-empty packet into the readable half of the double buffer
  function automatic void publish_packet();
    rx_mode = RX_IDLE;
    if (fill_cnt == 0) return;
    back_is_b = ~back_is_b;
    pkt_total = pkt_total + 1;
    ready_cnt = fill_cnt;
    fill_cnt  = 0;
  endfunction

  function automatic void framing_fault();
    ferr_total = ferr_total + 1;
    link_up    = 1'b0;
    fill_cnt   = 0;
    publish_packet();
  endfunction

  function automatic void take_slot(logic [TimeW-1:0] t, logic [ByteW-1:0] b);
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] interval;
    since = t - brk_t;
    if (rx_mode == RX_BREAK) begin
      if (since < FirstSlotMinUs) begin
        framing_fault();
        return;
      end
      // close the previous packet and judge its break-to-break interval
      if (link_up) begin
        interval = brk_t - prev_brk_t;
        if (interval < lim_min_pkt) begin
          short_total = short_total + 1;
          fill_cnt    = 0;
        end else if (interval > lim_max_pkt) begin
          tmo_total = tmo_total + 1;
        end
        publish_packet();
      end
      prev_brk_t = brk_t;
      link_up    = 1'b1;
      rx_mode    = RX_DATA;
    end else if (rx_mode == RX_DATA) begin
      if (since < FirstSlotMinUs + SlotTimeUs * fill_cnt) begin
        framing_fault();
        return;
      end
    end else begin
      return;
    end
    last_slot_t = t;
    if (since > lim_max_pkt) begin
      tmo_total = tmo_total + 1;
      publish_packet();
      return;
    end
    if (fill_cnt < MaxSlots) begin
      if (back_is_b) slot_b[AddrW'(fill_cnt)] = b;
      else slot_a[AddrW'(fill_cnt)] = b;
      fill_cnt = fill_cnt + 1;
    end
    if (fill_cnt >= MaxSlots) publish_packet();
  endfunction

  function automatic void poll_idle(logic [TimeW-1:0] t);
    if (rx_mode != RX_DATA) return;
    if ((t - brk_t) > lim_max_pkt || (t - last_slot_t) >= lim_idle) begin
      tmo_total = tmo_total + 1;
      link_up   = 1'b0;
      publish_packet();
    end
  endfunction

  // Advance the model by one event and return the status it reports
  function automatic dmx_status_t next_status(dmx_event_t e);
    dmx_status_t s;
    s = '0;
    case (e.act)
      ACT_BYTE:      take_slot(e.t, e.data);
      ACT_BREAK: begin
        brk_t   = e.t - SlotTimeUs;
        rx_mode = RX_BREAK;
      end
      ACT_BAD_BREAK: framing_fault();
      ACT_TICK:      poll_idle(e.t);
      ACT_READ: begin
        if (ready_cnt != 0) begin
          if (e.chan < ready_cnt && e.chan < MaxSlots) begin
            s.rd_valid = 1'b1;
            s.rd_data  = back_is_b ? slot_a[e.chan] : slot_b[e.chan];
          end
          if (e.rel) ready_cnt = 0;
        end
      end
      default: ;
    endcase
    s.size  = PktSizeW'(ready_cnt);
    s.state = rx_mode;
    s.conn  = link_up;
    s.pkts  = pkt_total;
    s.tmo   = tmo_total;
    s.ferr  = ferr_total;
    s.shrt  = short_total;
    return s;
  endfunction

  function automatic string status_str(dmx_status_t s);
    return $sformatf("rd_valid=%0d rd_data=%02h size=%0d state=%0d conn=%0d %s",
                     s.rd_valid, s.rd_data, s.size, s.state, s.conn,
                     $sformatf("pkts=%0d tmo=%0d ferr=%0d short=%0d",
                               s.pkts, s.tmo, s.ferr, s.shrt));
  endfunction

  // Queue one event for the driver
  task automatic push_ev(logic [ActionW-1:0] a, logic [TimeW-1:0] t, logic [ByteW-1:0] d,
                         logic [ChanW-1:0] c, logic r);
    dmx_event_t e;
    e.act  = a;
    e.t    = t;
    e.data = d;
    e.chan = c;
    e.rel  = r;
    pending_events.push_back(e);
    gen_count++;
  endtask

  // Read a slot, mostly inside the last generated packet
  task automatic push_read(logic [TimeW-1:0] t);
    logic [ChanW-1:0] chan;
    chan = ($urandom_range(0, 3) == 0) ? ChanW'($urandom_range(0, MaxSlots - 1)) :
                                         ChanW'($urandom_range(0, gen_len));
    push_ev(ACT_READ, t, ByteW'($urandom_range(0, 255)), chan, $urandom_range(0, 3) == 0);
  endtask

  task automatic push_byte(logic [TimeW-1:0] t);
    push_ev(ACT_BYTE, t, ByteW'($urandom_range(0, 255)),
            ChanW'($urandom_range(0, MaxSlots - 1)), 1'($urandom_range(0, 1)));
  endtask

  // Break followed by n slots at legal spacing; optionally one slot arrives early
  task automatic gen_packet(int unsigned n, bit broken);
    logic [TimeW-1:0] tb;
    logic [TimeW-1:0] t;
    int unsigned      bad_at;
    int unsigned      k;
    bad_at = broken ? $urandom_range(0, n - 1) : n;
    tb = gen_now;
    push_ev(ACT_BREAK, tb, ByteW'($urandom_range(0, 255)),
            ChanW'($urandom_range(0, MaxSlots - 1)), 1'b0);
    t = tb + FirstSlotLead + $urandom_range(0, 10);
    for (k = 0; k < n; k++) begin
      if (k == bad_at) push_byte(tb + FirstSlotLead - 1 + SlotTimeUs * k - $urandom_range(0, 40));
      else push_byte(t);
      t = t + SlotTimeUs + $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 8) push_read(t);
    end
    gen_len = n;
    // gap before the next break sets the break-to-break interval
    if ($urandom_range(0, 19) == 0) gen_now = t + gen_max_pkt + $urandom_range(0, 5000);
    else gen_now = t + $urandom_range(0, 1300);
  endtask

  // Mostly well-formed packets, the rest broken framing, polls, reads and noise
  task automatic gen_random(int budget);
    int          stop;
    int unsigned pick;
    int unsigned k;
    stop = gen_count + budget;
    while (gen_count < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        gen_packet(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 30),
                   $urandom_range(0, 14) == 0);
      end else if (pick < 68) begin
        push_ev(ACT_BAD_BREAK, gen_now, ByteW'($urandom_range(0, 255)),
                ChanW'($urandom_range(0, MaxSlots - 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 78) begin
        push_ev(ACT_BREAK, gen_now, ByteW'($urandom_range(0, 255)), '0, 1'b0);
        if ($urandom_range(0, 1)) push_byte(gen_now + $urandom_range(0, FirstSlotLead - 1));
        else push_byte(gen_now + gen_max_pkt + $urandom_range(0, 200));
        gen_now = gen_now + gen_max_pkt + 2000;
      end else if (pick < 88) begin
        case ($urandom_range(0, 2))
          0:       gen_now = gen_now + $urandom_range(0, 100);
          1:       gen_now = gen_now + gen_idle + $urandom_range(0, 2) - 1;
          default: gen_now = $urandom();
        endcase
        push_ev(ACT_TICK, gen_now, ByteW'($urandom_range(0, 255)),
                ChanW'($urandom_range(0, MaxSlots - 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        for (k = 0; k < $urandom_range(1, 3); k++) push_read(gen_now);
      end else begin
        push_ev(ActionW'($urandom_range(0, ActLast)), $urandom(),
                ByteW'($urandom_range(0, 255)), ChanW'($urandom_range(0, MaxSlots - 1)),
                1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Write all three limit registers through the configuration channel
  task automatic set_limits(logic [TimeW-1:0] min_us, logic [TimeW-1:0] max_us,
                            logic [TimeW-1:0] idle_us);
    logic [TimeW-1:0] vals [3];
    cfg_reg_e         regs [3];
    int               i;
    vals = '{min_us, max_us, idle_us};
    regs = '{CFG_MIN_PACKET, CFG_MAX_PACKET, CFG_MAX_IDLE};
    gen_max_pkt = max_us;
    gen_idle    = idle_us;
    for (i = 0; i < 3; i++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every event is taken and every status has come back
  task automatic wait_idle();
    while (pending_events.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (DrainPause) @(negedge clk_i);
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Driver: present the next event, hold it while stalled
  always @(negedge clk_i) begin : driver
    dmx_event_t e;
    if (rst_ni && (!in_valid_i || event_taken)) begin
      if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        e = pending_events.pop_front();
        in_valid_i       <= 1'b1;
        action_i         <= e.act;
        time_us_i        <= e.t;
        data_byte_i      <= e.data;
        read_channel_i   <= e.chan;
        release_packet_i <= e.rel;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Sink: random stalls, a calm stretch, and one long hold-off
  always @(negedge clk_i) begin : sink
    int hold_left;
    bit held;
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!held && events_taken >= HoldAt) begin
      held = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Monitor: predict on accepted events, check accepted results
  always @(posedge clk_i) begin : monitor
    dmx_event_t  ev;
    dmx_status_t got;
    dmx_status_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MIN_PACKET: lim_min_pkt = cfg_data_i;
          CFG_MAX_PACKET: lim_max_pkt = cfg_data_i;
          CFG_MAX_IDLE:   lim_idle    = cfg_data_i;
          default: ;
        endcase
      end
      event_taken = in_valid_i && !in_stall_o;
      if (event_taken) begin
        ev.act  = action_i;
        ev.t    = time_us_i;
        ev.data = data_byte_i;
        ev.chan = read_channel_i;
        ev.rel  = release_packet_i;
        expected_status.push_back(next_status(ev));
        events_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got.rd_valid = read_valid_o;
        got.rd_data  = read_data_o;
        got.size     = packet_size_o;
        got.state    = receiver_state_o;
        got.conn     = connected_o;
        got.pkts     = packet_count_o;
        got.tmo      = timeout_count_o;
        got.ferr     = framing_error_count_o;
        got.shrt     = short_packet_count_o;
        if (expected_status.size() == 0) begin
          if (n_err < MaxReports)
            $display("%0t: result with no transaction pending: %s", $time, status_str(got));
          n_err++;
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            if (n_err < MaxReports) begin
              $display("%0t: mismatch", $time);
              $display("  expected %s", status_str(want));
              $display("  actual   %s", status_str(got));
            end
            n_err++;
          end
        end
      end
    end
  end

  // Stimulus: directed checks, then random phases at several limit settings
  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reads, bytes and polls with nothing received, unknown actions
    push_ev(ACT_READ, '0, '0, '0, 1'b1);
    push_ev(ACT_BYTE, '1, '1, ChanW'(MaxSlots - 1), 1'b1);
    push_ev(ACT_TICK, '0, '0, '0, 1'b0);
    push_ev(ActionW'(ACT_READ + 1), '1, '1, ChanW'(MaxSlots - 1), 1'b1);
    push_ev(ActionW'(ACT_READ + 2), '0, '0, '0, 1'b0);
    push_ev(ActLast, '1, '1, ChanW'(MaxSlots - 1), 1'b1);
    // bad break with nothing buffered, then a first slot that comes too early
    push_ev(ACT_BAD_BREAK, '0, '0, '0, 1'b0);
    push_ev(ACT_BREAK, 1000, '0, '0, 1'b0);
    push_ev(ACT_BYTE, 1050, 8'h5A, '0, 1'b0);
    // three slots exactly at the timing limits
    push_ev(ACT_BREAK, 2000, '0, '0, 1'b0);
    push_ev(ACT_BYTE, 2096, 8'h00, '0, 1'b0);
    push_ev(ACT_BYTE, 2140, 8'hFF, '0, 1'b0);
    push_ev(ACT_BYTE, 2184, 8'hA5, '0, 1'b0);
    // break too soon after the last one: short packet, then two slots
    push_ev(ACT_BREAK, 2300, '0, '0, 1'b0);
    push_ev(ACT_BYTE, 2396, 8'h3C, '0, 1'b0);
    push_ev(ACT_BYTE, 2440, 8'hC3, '0, 1'b0);
    // next break and its first slot publish those two slots
    push_ev(ACT_BREAK, 4000, '0, '0, 1'b0);
    push_ev(ACT_BYTE, 4096, 8'h81, '0, 1'b0);
    push_ev(ACT_READ, '0, '0, ChanW'(0), 1'b0);
    push_ev(ACT_READ, '0, '0, ChanW'(1), 1'b0);
    push_ev(ACT_READ, '0, '0, ChanW'(2), 1'b0);
    push_ev(ACT_READ, '0, '0, ChanW'(MaxSlots - 1), 1'b1);
    push_ev(ACT_READ, '0, '0, ChanW'(0), 1'b0);
    // idle timeout, then a first slot past the packet limit
    push_ev(ACT_TICK, 4096 + MaxIdleRst, '0, '0, 1'b0);
    push_ev(ACT_BREAK, 2_000_000, '0, '0, 1'b0);
    push_ev(ACT_BYTE, 3_000_100, 8'h11, '0, 1'b0);
    wait_idle();

    // widest limits, plus one full-size packet with a few trailing bytes
    set_limits('0, '1, '1);
    gen_now = $urandom();
    gen_random(120);
    gen_packet(MaxSlots + 4, 1'b0);
    wait_idle();

    // tight limits, timestamps wrapping through zero
    set_limits(MinPacketRst, 5000, 400);
    gen_now = 32'hFFFF_F000;
    gen_random(160);
    wait_idle();

    // every packet short, every slot and poll over the limits
    set_limits('1, '0, '0);
    gen_random(80);
    wait_idle();

    // back to the reset values
    set_limits(MinPacketRst, MaxPacketRst, MaxIdleRst);
    gen_random(160);
    wait_idle();

    if (n_err == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
